FILE: hdl/tmse_pkg.sv
// Shared types, constants and command codes of the Turing machine step engine.
package tmse_pkg;

   localparam int TAPE_CELLS = 1024;
   localparam int TAPE_W     = 10;
   localparam int SYM_W      = 8;
   localparam int STATE_W    = 4;
   localparam int NEXT_W     = 5;
   localparam int MOVE_W     = 2;
   localparam int ENTRY_W    = SYM_W + MOVE_W + NEXT_W;
   localparam int CMD_W      = 3;
   localparam int STATUS_W   = 2;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 8;

   localparam logic [SYM_W-1:0]  BLANK_RST = 8'd94;
   localparam logic [NEXT_W-1:0] SIU_RST   = 5'd1;
   localparam logic [TAPE_W-1:0] HEAD_RST  = TAPE_W'(TAPE_CELLS / 2);
   localparam logic [TAPE_W-1:0] HEAD_LAST = TAPE_W'(TAPE_CELLS - 1);

   localparam logic [CMD_W-1:0] CMD_STEP    = 3'd0;
   localparam logic [CMD_W-1:0] CMD_TBL_WR  = 3'd1;
   localparam logic [CMD_W-1:0] CMD_TBL_RD  = 3'd2;
   localparam logic [CMD_W-1:0] CMD_CELL_WR = 3'd3;
   localparam logic [CMD_W-1:0] CMD_CELL_RD = 3'd4;
   localparam logic [CMD_W-1:0] CMD_RUN_RST = 3'd5;

   localparam logic [STATUS_W-1:0] STS_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] STS_HALTED   = 2'd1;
   localparam logic [STATUS_W-1:0] STS_BADENTRY = 2'd2;
   localparam logic [STATUS_W-1:0] STS_OFFTAPE  = 2'd3;

   localparam logic [MOVE_W-1:0] MV_NONE  = 2'd0;
   localparam logic [MOVE_W-1:0] MV_LEFT  = 2'd1;
   localparam logic [MOVE_W-1:0] MV_RIGHT = 2'd2;
   localparam logic [MOVE_W-1:0] MV_HALT  = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_STATES_IN_USE = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_BLANK         = 1'b1;

   typedef enum logic [2:0] {
      FSM_CLEAR,
      FSM_IDLE,
      FSM_LOOKUP,
      FSM_APPLY,
      FSM_SWEEP,
      FSM_FINISH
   } fsm_type;

   typedef struct packed {
      logic accept;
      logic lookup;
      logic apply;
      logic sweep;
      logic clear;
      logic finish;
   } ctrl_cmd_type;

   typedef struct packed {
      logic halted;
      logic sweep_done;
      logic out_free;
   } dp_stat_type;

endpackage

FILE: hdl/turing_machine_step_engine_core.sv
// Top level of the Turing machine step engine: controller plus datapath.
//
//   channel   direction  handshake               payload
//   req_*     in         req_valid / req_stall   command and its operands
//   rsp_*     out        rsp_valid / rsp_stall   status, machine state, read data
//   csr_*     in         csr_we                  csr_index, csr_wdata
//
// A step runs through accept, table lookup, apply and finish: tape read, table read
// and tape write-back are dependent accesses to synchronous-read memories.
// A step while halted and the table, cell and unused commands go straight to finish;
// a run reset sweeps the tape one cell a cycle. After reset a clearing pass over
// max(TAPE_CELLS, STATES*256) entries (4096 by default) runs with req_stall high.
// A stalled result holds in the output register; the finishing command waits there.
module turing_machine_step_engine_core #(
   parameter int STATES = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [tmse_pkg::CMD_W-1:0]      req_cmd,
   input  logic [tmse_pkg::STATE_W-1:0]    req_state_index,
   input  logic [tmse_pkg::SYM_W-1:0]      req_symbol_key,
   input  logic [tmse_pkg::SYM_W-1:0]      req_write_symbol,
   input  logic [tmse_pkg::MOVE_W-1:0]     req_move_code,
   input  logic [tmse_pkg::NEXT_W-1:0]     req_next_state,
   input  logic [tmse_pkg::TAPE_W-1:0]     req_cell_index,
   input  logic [tmse_pkg::SYM_W-1:0]      req_cell_value,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [tmse_pkg::STATUS_W-1:0]   rsp_status,
   output logic                            rsp_halted,
   output logic [tmse_pkg::TAPE_W-1:0]     rsp_head_position,
   output logic [tmse_pkg::STATE_W-1:0]    rsp_machine_state,
   output logic [tmse_pkg::SYM_W-1:0]      rsp_cell_out,
   output logic [tmse_pkg::SYM_W-1:0]      rsp_entry_symbol_out,
   output logic [tmse_pkg::MOVE_W-1:0]     rsp_entry_move_out,
   output logic [tmse_pkg::NEXT_W-1:0]     rsp_entry_next_out,
   input  logic                            csr_we,
   input  logic [tmse_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [tmse_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import tmse_pkg::*;

   ctrl_cmd_type ctrl_cmd;
   dp_stat_type  dp_stat;

   tmse_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_cmd   (req_cmd),
      .req_stall (req_stall),
      .stat      (dp_stat),
      .cmd       (ctrl_cmd)
   );

   tmse_datapath #(
      .STATES (STATES)
   ) u_datapath (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (ctrl_cmd),
      .stat                 (dp_stat),
      .req_cmd              (req_cmd),
      .req_state_index      (req_state_index),
      .req_symbol_key       (req_symbol_key),
      .req_write_symbol     (req_write_symbol),
      .req_move_code        (req_move_code),
      .req_next_state       (req_next_state),
      .req_cell_index       (req_cell_index),
      .req_cell_value       (req_cell_value),
      .rsp_stall            (rsp_stall),
      .rsp_valid            (rsp_valid),
      .rsp_status           (rsp_status),
      .rsp_halted           (rsp_halted),
      .rsp_head_position    (rsp_head_position),
      .rsp_machine_state    (rsp_machine_state),
      .rsp_cell_out         (rsp_cell_out),
      .rsp_entry_symbol_out (rsp_entry_symbol_out),
      .rsp_entry_move_out   (rsp_entry_move_out),
      .rsp_entry_next_out   (rsp_entry_next_out),
      .csr_we               (csr_we),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata)
   );

endmodule

FILE: hdl/tmse_ctrl.sv
// Controller state machine of the Turing machine step engine.
module tmse_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic [tmse_pkg::CMD_W-1:0] req_cmd,
   output logic                      req_stall,
   input  tmse_pkg::dp_stat_type     stat,
   output tmse_pkg::ctrl_cmd_type    cmd
);
   import tmse_pkg::*;

   fsm_type fsm_ff;
   fsm_type fsm_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         fsm_ff <= FSM_CLEAR;
      end else begin
         fsm_ff <= fsm_in;
      end
   end

   always_comb begin
      fsm_in = fsm_ff;
      case (fsm_ff)
         FSM_CLEAR: begin
            if (stat.sweep_done) fsm_in = FSM_IDLE;
         end
         FSM_IDLE: begin
            if (req_valid) begin
               if (req_cmd == CMD_STEP && !stat.halted) fsm_in = FSM_LOOKUP;
               else if (req_cmd == CMD_RUN_RST) fsm_in = FSM_SWEEP;
               else fsm_in = FSM_FINISH;
            end
         end
         FSM_LOOKUP: fsm_in = FSM_APPLY;
         FSM_APPLY:  fsm_in = FSM_FINISH;
         FSM_SWEEP: begin
            if (stat.sweep_done) fsm_in = FSM_FINISH;
         end
         FSM_FINISH: begin
            if (stat.out_free) fsm_in = FSM_IDLE;
         end
         default: fsm_in = FSM_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      case (fsm_ff)
         FSM_CLEAR: begin
            cmd.sweep = 1'b1;
            cmd.clear = 1'b1;
         end
         FSM_IDLE: begin
            req_stall  = 1'b0;
            cmd.accept = req_valid;
         end
         FSM_LOOKUP: cmd.lookup = 1'b1;
         FSM_APPLY:  cmd.apply  = 1'b1;
         FSM_SWEEP:  cmd.sweep  = 1'b1;
         FSM_FINISH: cmd.finish = stat.out_free;
         default: ;
      endcase
   end

   a_one_action: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.accept, cmd.lookup, cmd.apply, cmd.sweep, cmd.finish}))
      else $error("more than one datapath action in a cycle");

   a_run_reset_sweeps: assert property (@(posedge clock) disable iff (reset)
      (cmd.accept && req_cmd == CMD_RUN_RST) |=> (cmd.sweep && !cmd.clear))
      else $error("run reset did not start a tape sweep");

   a_finish_holds: assert property (@(posedge clock) disable iff (reset)
      (fsm_ff == FSM_FINISH && !stat.out_free) |=> (fsm_ff == FSM_FINISH))
      else $error("finishing command left while the result beat was blocked");

endmodule

FILE: hdl/tmse_datapath.sv
// Datapath of the Turing machine step engine: tape, transition table, machine registers.
module tmse_datapath #(
   parameter int STATES = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  tmse_pkg::ctrl_cmd_type          cmd,
   output tmse_pkg::dp_stat_type           stat,
   input  logic [tmse_pkg::CMD_W-1:0]      req_cmd,
   input  logic [tmse_pkg::STATE_W-1:0]    req_state_index,
   input  logic [tmse_pkg::SYM_W-1:0]      req_symbol_key,
   input  logic [tmse_pkg::SYM_W-1:0]      req_write_symbol,
   input  logic [tmse_pkg::MOVE_W-1:0]     req_move_code,
   input  logic [tmse_pkg::NEXT_W-1:0]     req_next_state,
   input  logic [tmse_pkg::TAPE_W-1:0]     req_cell_index,
   input  logic [tmse_pkg::SYM_W-1:0]      req_cell_value,
   input  logic                            rsp_stall,
   output logic                            rsp_valid,
   output logic [tmse_pkg::STATUS_W-1:0]   rsp_status,
   output logic                            rsp_halted,
   output logic [tmse_pkg::TAPE_W-1:0]     rsp_head_position,
   output logic [tmse_pkg::STATE_W-1:0]    rsp_machine_state,
   output logic [tmse_pkg::SYM_W-1:0]      rsp_cell_out,
   output logic [tmse_pkg::SYM_W-1:0]      rsp_entry_symbol_out,
   output logic [tmse_pkg::MOVE_W-1:0]     rsp_entry_move_out,
   output logic [tmse_pkg::NEXT_W-1:0]     rsp_entry_next_out,
   input  logic                            csr_we,
   input  logic [tmse_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [tmse_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import tmse_pkg::*;

   localparam int ROW_W     = (STATES > 1) ? $clog2(STATES) : 1;
   localparam int TBL_AW    = ROW_W + SYM_W;
   localparam int TBL_DEPTH = STATES * 256;
   localparam int CLR_DEPTH = (TBL_DEPTH > TAPE_CELLS) ? TBL_DEPTH : TAPE_CELLS;
   localparam int CLR_W     = $clog2(CLR_DEPTH);
   localparam int LIVE_CAP  = (STATES < 16) ? STATES : 16;

   // memories
   logic [SYM_W-1:0]   tape_mem [TAPE_CELLS];
   logic [ENTRY_W-1:0] tbl_mem  [TBL_DEPTH];

   logic               tape_we, tape_re;
   logic [TAPE_W-1:0]  tape_wa, tape_ra;
   logic [SYM_W-1:0]   tape_wd;
   logic [SYM_W-1:0]   tape_rd_ff;
   logic               tbl_we, tbl_re;
   logic [TBL_AW-1:0]  tbl_wa, tbl_ra;
   logic [ENTRY_W-1:0] tbl_wd;
   logic [ENTRY_W-1:0] tbl_rd_ff;

   // configuration
   logic [NEXT_W-1:0] siu_ff, siu_in;
   logic [SYM_W-1:0]  blank_ff, blank_in;
   logic [NEXT_W-1:0] live;

   // machine state
   logic [TAPE_W-1:0]  head_ff, head_in;
   logic [STATE_W-1:0] state_ff, state_in;
   logic               halted_ff, halted_in;

   // latched command
   logic [CMD_W-1:0]   cmd_ff, cmd_in;
   logic [STATE_W-1:0] row_ff, row_in;
   logic [SYM_W-1:0]   col_ff, col_in;
   logic [SYM_W-1:0]   wsym_ff, wsym_in;
   logic [MOVE_W-1:0]  mv_ff, mv_in;
   logic [NEXT_W-1:0]  nxt_ff, nxt_in;
   logic [TAPE_W-1:0]  cidx_ff, cidx_in;
   logic [SYM_W-1:0]   cval_ff, cval_in;

   // partial result
   logic [STATUS_W-1:0] sts_ff, sts_in;
   logic                use_rd_ff, use_rd_in;
   logic [SYM_W-1:0]    hold_ff, hold_in;

   // sweep counter
   logic [CLR_W-1:0] sweep_idx_ff, sweep_idx_in;
   logic             sweep_last, idx_in_tape, idx_in_tbl;

   // step evaluation
   logic [ENTRY_W-1:0] entry;
   logic [SYM_W-1:0]   ent_sym;
   logic [MOVE_W-1:0]  ent_move;
   logic [NEXT_W-1:0]  ent_next;
   logic [TAPE_W-1:0]  step_head;
   logic               step_off, step_moved;

   // finish
   logic                live_ok;
   logic [STATUS_W-1:0] res_status;

   // output register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic                rsp_halted_ff, rsp_halted_in;
   logic [TAPE_W-1:0]   rsp_head_ff, rsp_head_in;
   logic [STATE_W-1:0]  rsp_state_ff, rsp_state_in;
   logic [SYM_W-1:0]    rsp_cell_ff, rsp_cell_in;
   logic [SYM_W-1:0]    rsp_esym_ff, rsp_esym_in;
   logic [MOVE_W-1:0]   rsp_emv_ff, rsp_emv_in;
   logic [NEXT_W-1:0]   rsp_enx_ff, rsp_enx_in;

   // ---------------- configuration ----------------
   always_comb begin
      siu_in   = siu_ff;
      blank_in = blank_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_STATES_IN_USE: siu_in = csr_wdata[NEXT_W-1:0];
            CSR_BLANK:         blank_in = csr_wdata[SYM_W-1:0];
            default: ;
         endcase
      end
   end

   assign live = (siu_ff > NEXT_W'(LIVE_CAP)) ? NEXT_W'(LIVE_CAP) : siu_ff;

   // ---------------- sweep counter ----------------
   always_comb begin
      if (cmd.clear) sweep_last = (sweep_idx_ff == CLR_W'(CLR_DEPTH - 1));
      else sweep_last = (sweep_idx_ff == CLR_W'(TAPE_CELLS - 1));
      idx_in_tape  = ({1'b0, sweep_idx_ff} < (CLR_W + 1)'(TAPE_CELLS));
      idx_in_tbl   = ({1'b0, sweep_idx_ff} < (CLR_W + 1)'(TBL_DEPTH));
      sweep_idx_in = sweep_idx_ff;
      if (cmd.sweep) sweep_idx_in = sweep_last ? '0 : sweep_idx_ff + 1'b1;
   end

   // ---------------- step evaluation ----------------
   always_comb begin
      // a control state without a table row sees an empty entry
      entry      = (int'(state_ff) < STATES) ? tbl_rd_ff : '0;
      ent_sym    = entry[SYM_W-1:0];
      ent_move   = entry[SYM_W +: MOVE_W];
      ent_next   = entry[SYM_W + MOVE_W +: NEXT_W];
      step_head  = head_ff;
      step_off   = 1'b0;
      step_moved = 1'b0;
      case (ent_move)
         MV_LEFT: begin
            if (head_ff == '0) step_off = 1'b1;
            else begin
               step_head  = head_ff - 1'b1;
               step_moved = 1'b1;
            end
         end
         MV_RIGHT: begin
            if (head_ff == HEAD_LAST) step_off = 1'b1;
            else begin
               step_head  = head_ff + 1'b1;
               step_moved = 1'b1;
            end
         end
         default: ;
      endcase
   end

   // ---------------- machine registers ----------------
   always_comb begin
      head_in   = head_ff;
      state_in  = state_ff;
      halted_in = halted_ff;
      if (cmd.apply) begin
         head_in = step_head;
         if (ent_move == MV_HALT) halted_in = 1'b1;
         if (ent_next != '0) state_in = STATE_W'(ent_next - 1'b1);
      end else if (cmd.finish && cmd_ff == CMD_RUN_RST) begin
         head_in   = HEAD_RST;
         state_in  = '0;
         halted_in = 1'b0;
      end
   end

   // ---------------- command latch and partial result ----------------
   always_comb begin
      cmd_in    = cmd_ff;
      row_in    = row_ff;
      col_in    = col_ff;
      wsym_in   = wsym_ff;
      mv_in     = mv_ff;
      nxt_in    = nxt_ff;
      cidx_in   = cidx_ff;
      cval_in   = cval_ff;
      sts_in    = sts_ff;
      use_rd_in = use_rd_ff;
      hold_in   = hold_ff;
      if (cmd.accept) begin
         cmd_in    = req_cmd;
         row_in    = req_state_index;
         col_in    = req_symbol_key;
         wsym_in   = req_write_symbol;
         mv_in     = req_move_code;
         nxt_in    = req_next_state;
         cidx_in   = req_cell_index;
         cval_in   = req_cell_value;
         sts_in    = (req_cmd == CMD_STEP && halted_ff) ? STS_HALTED : STS_OK;
         use_rd_in = (req_cmd == CMD_CELL_RD) || (req_cmd == CMD_STEP && halted_ff);
         hold_in   = '0;
      end else if (cmd.apply) begin
         sts_in    = step_off ? STS_OFFTAPE : STS_OK;
         // after a move the new cell is read back; otherwise the cell is known here
         use_rd_in = step_moved;
         hold_in   = (ent_sym != '0) ? ent_sym : tape_rd_ff;
      end
   end

   // ---------------- memory ports ----------------
   always_comb begin
      tape_we = 1'b0;
      tape_wa = head_ff;
      tape_wd = ent_sym;
      if (cmd.sweep) begin
         tape_we = idx_in_tape;
         tape_wa = sweep_idx_ff[TAPE_W-1:0];
         tape_wd = cmd.clear ? BLANK_RST : blank_ff;
      end else if (cmd.apply) begin
         tape_we = (ent_sym != '0);
      end else if (cmd.finish && cmd_ff == CMD_CELL_WR) begin
         tape_we = 1'b1;
         tape_wa = cidx_ff;
         tape_wd = cval_ff;
      end
      tape_re = cmd.accept || cmd.apply;
      if (cmd.accept) tape_ra = (req_cmd == CMD_CELL_RD) ? req_cell_index : head_ff;
      else tape_ra = step_head;
   end

   assign live_ok = ({1'b0, row_ff} < live);

   always_comb begin
      tbl_we = 1'b0;
      tbl_wa = {ROW_W'(row_ff), col_ff};
      tbl_wd = (nxt_ff > live) ? '0 : {nxt_ff, mv_ff, wsym_ff};
      if (cmd.clear) begin
         tbl_we = idx_in_tbl;
         tbl_wa = sweep_idx_ff[TBL_AW-1:0];
         tbl_wd = '0;
      end else if (cmd.finish && cmd_ff == CMD_TBL_WR) begin
         tbl_we = live_ok;
      end
      tbl_re = cmd.accept || cmd.lookup;
      if (cmd.accept) tbl_ra = {ROW_W'(req_state_index), req_symbol_key};
      else tbl_ra = {ROW_W'(state_ff), tape_rd_ff};
   end

   always_ff @(posedge clock) begin
      if (tape_we) tape_mem[tape_wa] <= tape_wd;
      if (tape_re) tape_rd_ff <= tape_mem[tape_ra];
   end

   always_ff @(posedge clock) begin
      if (tbl_we) tbl_mem[tbl_wa] <= tbl_wd;
      if (tbl_re) tbl_rd_ff <= tbl_mem[tbl_ra];
   end

   // ---------------- result ----------------
   always_comb begin
      res_status = sts_ff;
      if ((cmd_ff == CMD_TBL_WR || cmd_ff == CMD_TBL_RD) && !live_ok) begin
         res_status = STS_BADENTRY;
      end else if (cmd_ff == CMD_TBL_WR && nxt_ff > live) begin
         res_status = STS_BADENTRY;
      end
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_halted_in = rsp_halted_ff;
      rsp_head_in   = rsp_head_ff;
      rsp_state_in  = rsp_state_ff;
      rsp_cell_in   = rsp_cell_ff;
      rsp_esym_in   = rsp_esym_ff;
      rsp_emv_in    = rsp_emv_ff;
      rsp_enx_in    = rsp_enx_ff;
      if (cmd.finish) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = res_status;
         rsp_halted_in = halted_in;
         rsp_head_in   = head_in;
         rsp_state_in  = state_in;
         rsp_cell_in   = use_rd_ff ? tape_rd_ff : hold_ff;
         rsp_esym_in   = '0;
         rsp_emv_in    = '0;
         rsp_enx_in    = '0;
         if (cmd_ff == CMD_TBL_RD && live_ok) begin
            rsp_esym_in = tbl_rd_ff[SYM_W-1:0];
            rsp_emv_in  = tbl_rd_ff[SYM_W +: MOVE_W];
            rsp_enx_in  = tbl_rd_ff[SYM_W + MOVE_W +: NEXT_W];
         end
      end
   end

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         siu_ff       <= SIU_RST;
         blank_ff     <= BLANK_RST;
         head_ff      <= HEAD_RST;
         state_ff     <= '0;
         halted_ff    <= 1'b0;
         sweep_idx_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         siu_ff       <= siu_in;
         blank_ff     <= blank_in;
         head_ff      <= head_in;
         state_ff     <= state_in;
         halted_ff    <= halted_in;
         sweep_idx_ff <= sweep_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      row_ff        <= row_in;
      col_ff        <= col_in;
      wsym_ff       <= wsym_in;
      mv_ff         <= mv_in;
      nxt_ff        <= nxt_in;
      cidx_ff       <= cidx_in;
      cval_ff       <= cval_in;
      sts_ff        <= sts_in;
      use_rd_ff     <= use_rd_in;
      hold_ff       <= hold_in;
      rsp_status_ff <= rsp_status_in;
      rsp_halted_ff <= rsp_halted_in;
      rsp_head_ff   <= rsp_head_in;
      rsp_state_ff  <= rsp_state_in;
      rsp_cell_ff   <= rsp_cell_in;
      rsp_esym_ff   <= rsp_esym_in;
      rsp_emv_ff    <= rsp_emv_in;
      rsp_enx_ff    <= rsp_enx_in;
   end

   assign stat.halted     = halted_ff;
   assign stat.sweep_done = sweep_last;
   assign stat.out_free   = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_status           = rsp_status_ff;
   assign rsp_halted           = rsp_halted_ff;
   assign rsp_head_position    = rsp_head_ff;
   assign rsp_machine_state    = rsp_state_ff;
   assign rsp_cell_out         = rsp_cell_ff;
   assign rsp_entry_symbol_out = rsp_esym_ff;
   assign rsp_entry_move_out   = rsp_emv_ff;
   assign rsp_entry_next_out   = rsp_enx_ff;

   a_halt_from_step: assert property (@(posedge clock) disable iff (reset)
      $rose(halted_ff) |-> $past(cmd.apply))
      else $error("halt flag set outside a step");

   a_head_moves: assert property (@(posedge clock) disable iff (reset)
      !$stable(head_ff) |-> ($past(reset) || $past(cmd.apply) || $past(cmd.finish)))
      else $error("head changed outside a step or run reset");

   a_beat_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(cmd.finish))
      else $error("result beat without a finished command");

endmodule

FILE: test/tb_top.sv
// Self-checking testbench for the Turing machine step engine core.
module tb_top;
   import tmse_pkg::*;

   localparam int ROWS        = 16;
   localparam int RAND_ITEMS  = 2000;
   localparam int CYCLE_LIMIT = 2_000_000;

   localparam logic [CMD_W-1:0] CMD_SPARE_6 = 3'd6;
   localparam logic [CMD_W-1:0] CMD_SPARE_7 = 3'd7;

   typedef struct packed {
      logic [CMD_W-1:0]   cmd;
      logic [STATE_W-1:0] state_index;
      logic [SYM_W-1:0]   symbol_key;
      logic [SYM_W-1:0]   write_symbol;
      logic [MOVE_W-1:0]  move_code;
      logic [NEXT_W-1:0]  next_state;
      logic [TAPE_W-1:0]  cell_index;
      logic [SYM_W-1:0]   cell_value;
   } tm_cmd_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic                halted;
      logic [TAPE_W-1:0]   head;
      logic [STATE_W-1:0]  mstate;
      logic [SYM_W-1:0]    cell_sym;
      logic [SYM_W-1:0]    esym;
      logic [MOVE_W-1:0]   emv;
      logic [NEXT_W-1:0]   enx;
   } tm_rsp_type;

   typedef struct packed {
      logic [NEXT_W-1:0] nxt;
      logic [MOVE_W-1:0] mv;
      logic [SYM_W-1:0]  sym;
   } rule_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [CMD_W-1:0]      req_cmd = '0;
   logic [STATE_W-1:0]    req_state_index = '0;
   logic [SYM_W-1:0]      req_symbol_key = '0;
   logic [SYM_W-1:0]      req_write_symbol = '0;
   logic [MOVE_W-1:0]     req_move_code = '0;
   logic [NEXT_W-1:0]     req_next_state = '0;
   logic [TAPE_W-1:0]     req_cell_index = '0;
   logic [SYM_W-1:0]      req_cell_value = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [STATUS_W-1:0]   rsp_status;
   logic                  rsp_halted;
   logic [TAPE_W-1:0]     rsp_head_position;
   logic [STATE_W-1:0]    rsp_machine_state;
   logic [SYM_W-1:0]      rsp_cell_out;
   logic [SYM_W-1:0]      rsp_entry_symbol_out;
   logic [MOVE_W-1:0]     rsp_entry_move_out;
   logic [NEXT_W-1:0]     rsp_entry_next_out;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   turing_machine_step_engine_core #(.STATES(ROWS)) uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_cmd(req_cmd),
      .req_state_index(req_state_index),
      .req_symbol_key(req_symbol_key),
      .req_write_symbol(req_write_symbol),
      .req_move_code(req_move_code),
      .req_next_state(req_next_state),
      .req_cell_index(req_cell_index),
      .req_cell_value(req_cell_value),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_status(rsp_status),
      .rsp_halted(rsp_halted),
      .rsp_head_position(rsp_head_position),
      .rsp_machine_state(rsp_machine_state),
      .rsp_cell_out(rsp_cell_out),
      .rsp_entry_symbol_out(rsp_entry_symbol_out),
      .rsp_entry_move_out(rsp_entry_move_out),
      .rsp_entry_next_out(rsp_entry_next_out),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   // machine image kept by the testbench
   logic [SYM_W-1:0]   tape_cells [0:TAPE_CELLS-1];
   rule_type           rule_table [0:ROWS*256-1];
   logic [TAPE_W-1:0]  head_pos;
   logic [STATE_W-1:0] ctl_state;
   logic               halt_flag;
   logic [NEXT_W-1:0]  states_cfg;
   logic [SYM_W-1:0]   blank_cfg;

   tm_cmd_type cmd_queue[$];
   tm_rsp_type pending_results[$];
   tm_cmd_type held_cmd;
   tm_rsp_type seen;
   tm_rsp_type want;

   int pushed_cnt = 0;
   int accepted_cnt = 0;
   int checked_cnt = 0;
   int mismatches = 0;
   int steps_taken = 0;
   int off_tape_moves = 0;
   int halted_steps = 0;
   int table_rejects = 0;
   int csr_writes = 0;
   int cycle_count = 0;
   int beat_gap = 0;
   int stall_left = 0;
   bit drv_quiet = 1'b0;
   bit mon_quiet = 1'b0;

   initial begin
      forever #6 clock = ~clock;
   end

   function automatic logic [NEXT_W-1:0] live_rows();
      return (states_cfg > NEXT_W'(ROWS)) ? NEXT_W'(ROWS) : states_cfg;
   endfunction

   function automatic void restart_run();
      for (int i = 0; i < TAPE_CELLS; i++) tape_cells[i] = blank_cfg;
      head_pos = HEAD_RST;
      ctl_state = '0;
      halt_flag = 1'b0;
   endfunction

   function automatic tm_rsp_type run_command(tm_cmd_type c);
      tm_rsp_type r;
      rule_type e;
      logic [SYM_W-1:0] sym;
      logic [NEXT_W-1:0] rows;
      r = '0;
      rows = live_rows();
      case (c.cmd)
         CMD_STEP: begin
            steps_taken++;
            if (halt_flag) begin
               r.status = STS_HALTED;
               halted_steps++;
            end else begin
               sym = tape_cells[head_pos];
               e = rule_table[{ctl_state, sym}];
               if (e.sym != '0) tape_cells[head_pos] = e.sym;
               if (e.mv == MV_LEFT) begin
                  if (head_pos == '0) r.status = STS_OFFTAPE;
                  else head_pos = head_pos - 1'b1;
               end else if (e.mv == MV_RIGHT) begin
                  if (head_pos == HEAD_LAST) r.status = STS_OFFTAPE;
                  else head_pos = head_pos + 1'b1;
               end else if (e.mv == MV_HALT) begin
                  halt_flag = 1'b1;
               end
               if (e.nxt != '0) ctl_state = STATE_W'(e.nxt - 1'b1);
               if (r.status == STS_OFFTAPE) off_tape_moves++;
            end
            r.cell_sym = tape_cells[head_pos];
         end
         CMD_TBL_WR: begin
            if (NEXT_W'(c.state_index) >= rows) begin
               r.status = STS_BADENTRY;
            end else if (c.next_state > rows) begin
               // entry is wiped when the next state is not defined
               rule_table[{c.state_index, c.symbol_key}] = '0;
               r.status = STS_BADENTRY;
            end else begin
               rule_table[{c.state_index, c.symbol_key}] =
                  {c.next_state, c.move_code, c.write_symbol};
            end
            if (r.status == STS_BADENTRY) table_rejects++;
         end
         CMD_TBL_RD: begin
            if (NEXT_W'(c.state_index) >= rows) begin
               r.status = STS_BADENTRY;
               table_rejects++;
            end else begin
               e = rule_table[{c.state_index, c.symbol_key}];
               r.esym = e.sym;
               r.emv = e.mv;
               r.enx = e.nxt;
            end
         end
         CMD_CELL_WR: tape_cells[c.cell_index] = c.cell_value;
         CMD_CELL_RD: r.cell_sym = tape_cells[c.cell_index];
         CMD_RUN_RST: restart_run();
         default: ;
      endcase
      r.halted = halt_flag;
      r.head = head_pos;
      r.mstate = ctl_state;
      return r;
   endfunction

   function automatic int idle_len();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      else if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic void flag_error(string what);
      mismatches++;
      if (mismatches <= 10) $display("ERROR: %s", what);
   endfunction

   function automatic string rsp_text(tm_rsp_type r);
      return $sformatf("sts=%0d hlt=%0d head=%0d st=%0d cell=%02h esym=%02h emv=%0d enx=%0d",
                       r.status, r.halted, r.head, r.mstate, r.cell_sym, r.esym, r.emv,
                       r.enx);
   endfunction

   // request driver: one beat per accepted command, random gaps in between
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         beat_gap = 0;
      end else begin
         if (req_valid && !req_stall) begin
            pending_results = {pending_results, run_command(held_cmd)};
            accepted_cnt++;
            if ($urandom_range(0, 39) == 0) drv_quiet = !drv_quiet;
         end
         if (!req_valid || !req_stall) begin
            if (beat_gap > 0) begin
               beat_gap--;
               req_valid <= 1'b0;
            end else if (cmd_queue.size() != 0) begin
               held_cmd = cmd_queue.pop_front();
               req_valid <= 1'b1;
               req_cmd <= held_cmd.cmd;
               req_state_index <= held_cmd.state_index;
               req_symbol_key <= held_cmd.symbol_key;
               req_write_symbol <= held_cmd.write_symbol;
               req_move_code <= held_cmd.move_code;
               req_next_state <= held_cmd.next_state;
               req_cell_index <= held_cmd.cell_index;
               req_cell_value <= held_cmd.cell_value;
               beat_gap = drv_quiet ? 0 : idle_len();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // response monitor and back-pressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            seen = {rsp_status, rsp_halted, rsp_head_position, rsp_machine_state,
                    rsp_cell_out, rsp_entry_symbol_out, rsp_entry_move_out,
                    rsp_entry_next_out};
            if (pending_results.size() == 0) begin
               flag_error($sformatf("unexpected beat: %s", rsp_text(seen)));
            end else begin
               want = pending_results.pop_front();
               checked_cnt++;
               if (seen !== want)
                  flag_error($sformatf("result %0d\n   expected %s\n   actual   %s",
                                       checked_cnt, rsp_text(want), rsp_text(seen)));
            end
            if ($urandom_range(0, 39) == 0) mon_quiet = !mon_quiet;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
            if (!mon_quiet && $urandom_range(0, 3) == 0) stall_left = idle_len();
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout: %0d of %0d commands answered", checked_cnt, pushed_cnt);
         $display("FAILED: results differ");
         $finish;
      end
   end

   function automatic tm_cmd_type any_item(logic [CMD_W-1:0] op);
      tm_cmd_type c;
      c.cmd = op;
      c.state_index = STATE_W'($urandom_range(0, 15));
      c.symbol_key = SYM_W'($urandom_range(0, 255));
      c.write_symbol = SYM_W'($urandom_range(0, 255));
      c.move_code = MOVE_W'($urandom_range(0, 3));
      c.next_state = NEXT_W'($urandom_range(0, 16));
      c.cell_index = TAPE_W'($urandom_range(0, TAPE_CELLS - 1));
      c.cell_value = SYM_W'($urandom_range(0, 255));
      return c;
   endfunction

   function automatic tm_cmd_type rule_item(logic [CMD_W-1:0] op, int row,
                                            logic [SYM_W-1:0] key,
                                            logic [SYM_W-1:0] wsym, logic [MOVE_W-1:0] mv,
                                            int nxt);
      tm_cmd_type c;
      c = any_item(op);
      c.state_index = STATE_W'(row);
      c.symbol_key = key;
      if (op == CMD_TBL_WR) begin
         c.write_symbol = wsym;
         c.move_code = mv;
         c.next_state = NEXT_W'(nxt);
      end
      return c;
   endfunction

   function automatic tm_cmd_type cell_item(logic [CMD_W-1:0] op, int idx,
                                            logic [SYM_W-1:0] val);
      tm_cmd_type c;
      c = any_item(op);
      c.cell_index = TAPE_W'(idx);
      if (op == CMD_CELL_WR) c.cell_value = val;
      return c;
   endfunction

   function automatic void push_cmd(tm_cmd_type c);
      cmd_queue = {cmd_queue, c};
      pushed_cnt++;
   endfunction

   task automatic drain();
      while (accepted_cnt != pushed_cnt || pending_results.size() != 0) @(posedge clock);
      // then let the bench idle between phases
      repeat (8) @(posedge clock);
   endtask

   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_STATES_IN_USE) states_cfg = val[NEXT_W-1:0];
      else blank_cfg = val;
      csr_writes++;
   endtask

   initial begin : stimulus
      tm_cmd_type c;
      logic [SYM_W-1:0] alpha [4];
      logic [SYM_W-1:0] wsym;
      logic [MOVE_W-1:0] mv;
      int rows, phase, nsteps, r, target;

      states_cfg = SIU_RST;
      blank_cfg = BLANK_RST;
      for (int i = 0; i < ROWS * 256; i++) rule_table[i] = '0;
      restart_run();

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed: one state in use, default blank
      push_cmd(cell_item(CMD_CELL_RD, HEAD_RST, 8'h00));
      push_cmd(cell_item(CMD_CELL_RD, 0, 8'h00));
      push_cmd(cell_item(CMD_CELL_RD, HEAD_LAST, 8'h00));
      push_cmd(any_item(CMD_STEP));                                 // empty table
      push_cmd(rule_item(CMD_TBL_WR, 0, BLANK_RST, 8'hFF, MV_RIGHT, 1));
      push_cmd(rule_item(CMD_TBL_WR, 1, 8'h00, 8'h01, MV_LEFT, 0));   // row not in use
      push_cmd(rule_item(CMD_TBL_WR, 0, 8'hFF, 8'h80, MV_NONE, 16));  // next state too big
      push_cmd(rule_item(CMD_TBL_RD, 0, BLANK_RST, 8'h00, MV_NONE, 0));
      push_cmd(rule_item(CMD_TBL_RD, 0, 8'hFF, 8'h00, MV_NONE, 0));
      push_cmd(rule_item(CMD_TBL_RD, 15, 8'h00, 8'h00, MV_NONE, 0));
      push_cmd(cell_item(CMD_CELL_WR, HEAD_LAST, 8'hFF));
      push_cmd(cell_item(CMD_CELL_WR, 0, 8'h00));
      push_cmd(cell_item(CMD_CELL_RD, HEAD_LAST, 8'h00));
      push_cmd(any_item(CMD_STEP));
      push_cmd(cell_item(CMD_CELL_RD, HEAD_RST, 8'h00));
      push_cmd(rule_item(CMD_TBL_WR, 0, BLANK_RST, 8'h00, MV_HALT, 0));
      push_cmd(any_item(CMD_STEP));
      push_cmd(any_item(CMD_STEP));                                 // refused, halted
      push_cmd(any_item(CMD_SPARE_6));
      push_cmd(any_item(CMD_SPARE_7));
      push_cmd(any_item(CMD_RUN_RST));
      push_cmd(rule_item(CMD_TBL_WR, 0, BLANK_RST, 8'h21, MV_LEFT, 0));
      push_cmd(any_item(CMD_STEP));
      drain();

      target = pushed_cnt + RAND_ITEMS;
      phase = 0;
      while (pushed_cnt < target) begin
         if (phase == 0) begin
            csr_write(CSR_STATES_IN_USE, 8'd16);
            csr_write(CSR_BLANK, 8'd255);
         end else if (phase == 1) begin
            csr_write(CSR_STATES_IN_USE, 8'd1);
            csr_write(CSR_BLANK, 8'd33);
         end else begin
            if ($urandom_range(0, 1) == 0)
               csr_write(CSR_STATES_IN_USE, CSR_DATA_W'($urandom_range(1, 16)));
            if ($urandom_range(0, 2) == 0)
               csr_write(CSR_BLANK, CSR_DATA_W'($urandom_range(33, 255)));
         end
         rows = int'(live_rows());

         if (phase == 1 || phase == 2) begin
            // walk the head over the whole half tape and past the end
            push_cmd(any_item(CMD_RUN_RST));
            push_cmd(rule_item(CMD_TBL_WR, 0, blank_cfg, 8'h00,
                               (phase == 1) ? MV_LEFT : MV_RIGHT, 1));
            for (int k = 0; k < TAPE_CELLS / 2 + 6; k++) push_cmd(any_item(CMD_STEP));
         end else if (phase > 2 && $urandom_range(0, 7) == 0) begin
            // unstructured commands
            nsteps = $urandom_range(30, 60);
            for (int k = 0; k < nsteps; k++) begin
               c = any_item(CMD_W'($urandom_range(0, 7)));
               if (c.cmd == CMD_RUN_RST && $urandom_range(0, 3) != 0) c.cmd = CMD_STEP;
               push_cmd(c);
            end
         end else begin
            if ($urandom_range(0, 3) != 0) push_cmd(any_item(CMD_RUN_RST));
            alpha[0] = blank_cfg;
            for (int k = 1; k < 4; k++) alpha[k] = SYM_W'($urandom_range(1, 255));
            for (int s = 0; s < rows; s++) begin
               for (int k = 0; k < 4; k++) begin
                  wsym = ($urandom_range(0, 3) == 0) ? 8'h00 : alpha[$urandom_range(0, 3)];
                  r = $urandom_range(0, 19);
                  mv = (r < 1) ? MV_HALT : (r < 3) ? MV_NONE : (r < 11) ? MV_LEFT : MV_RIGHT;
                  push_cmd(rule_item(CMD_TBL_WR, s, alpha[k], wsym, mv,
                                     ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, rows)));
                  if (rows < ROWS && $urandom_range(0, 11) == 0) begin
                     if ($urandom_range(0, 1) == 0)
                        push_cmd(rule_item(CMD_TBL_WR, $urandom_range(rows, 15), alpha[k],
                                           wsym, mv, 0));
                     else
                        push_cmd(rule_item(CMD_TBL_WR, s, SYM_W'($urandom_range(0, 255)),
                                           wsym, mv, $urandom_range(rows + 1, 16)));
                  end
               end
            end
            nsteps = $urandom_range(0, 6);
            for (int k = 0; k < nsteps; k++)
               push_cmd(cell_item(CMD_CELL_WR, int'(HEAD_RST) + $urandom_range(0, 16) - 8,
                                  alpha[$urandom_range(0, 3)]));
            nsteps = $urandom_range(20, 80);
            for (int k = 0; k < nsteps; k++) begin
               r = $urandom_range(0, 39);
               if (r == 0)
                  push_cmd(any_item(CMD_RUN_RST));
               else if (r < 3)
                  push_cmd(rule_item(CMD_TBL_RD, ($urandom_range(0, 3) == 0) ?
                                     $urandom_range(0, 15) : $urandom_range(0, rows - 1),
                                     alpha[$urandom_range(0, 3)], 8'h00, MV_NONE, 0));
               else if (r == 3)
                  push_cmd(cell_item(CMD_CELL_RD, int'(HEAD_RST) + $urandom_range(0, 32) - 16,
                                     8'h00));
               else
                  push_cmd(any_item(CMD_STEP));
            end
         end
         drain();
         phase++;
      end

      drain();
      repeat (40) @(posedge clock);
      $display("Run: %0d commands in %0d phases, %0d results checked, %0d config writes",
               pushed_cnt, phase, checked_cnt, csr_writes);
      $display("Steps: %0d total, %0d off the tape end, %0d while halted; %0d table rejects",
               steps_taken, off_tape_moves, halted_steps, table_rejects);
      if (mismatches == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule

FILE: files.f
hdl/tmse_pkg.sv
hdl/tmse_ctrl.sv
hdl/tmse_datapath.sv
hdl/turing_machine_step_engine_core.sv
test/tb_top.sv
